// ===== rtl/core/rs485_frame_receiver_macros.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef RS485_FRAME_RECEIVER_MACROS_SVH
`define RS485_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rfr_pkg.sv =====
// Shared types and constants of the RS-485 frame receiver.
package rfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] len_t;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam byte_t CH_SOH     = 8'h01;
  localparam byte_t CH_STX     = 8'h02;
  localparam byte_t CH_ETX     = 8'h03;
  localparam byte_t CH_EOT     = 8'h04;
  localparam byte_t CMD_PACKET = 8'h58;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 2'd1;

  localparam byte_t NODE_ADDR_RST  = 8'h00;
  localparam byte_t BCAST_ADDR_RST = 8'hFF;

endpackage

// ===== rtl/core/rfr_payload_ram.sv =====
// Payload buffer: one write port, one registered read port.
module rfr_payload_ram #(
  parameter int DEPTH = rfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rfr_pkg::byte_t  wr_data,
  input  logic [AW-1:0]   rd_addr,
  output rfr_pkg::byte_t  rd_data
);
  import rfr_pkg::*;

  byte_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/rs485_frame_receiver.sv =====
// RS-485 frame receiver: header hunt, payload buffering, checksum, readout.
// A received byte is taken on each input beat while no readout is running.
// After a good EOT beat the payload is read from the buffer one result at a
// time: a RAM read, then a load that waits for a free output register.
// in_ready is low for the readout. Synchronous reset clears control state
// and config; output data registers and the payload buffer are not cleared.
module rs485_frame_receiver #(
  parameter int MAX_PAYLOAD = rfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  rfr_pkg::byte_t                     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rfr_pkg::byte_t                     rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rfr_pkg::byte_t                     sender,
  output rfr_pkg::len_t                      frame_length,
  output rfr_pkg::byte_t                     payload_byte,
  output rfr_pkg::len_t                      byte_index,
  output logic                               last
);
  import rfr_pkg::*;
  `include "rs485_frame_receiver_macros.svh"

  localparam int AW = $clog2(MAX_PAYLOAD);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_PAYLOAD = 3'd1;
  localparam logic [2:0] PH_ETX     = 3'd2;
  localparam logic [2:0] PH_SUM     = 3'd3;
  localparam logic [2:0] PH_EOT     = 3'd4;

  byte_t      node_address, bcast_addr;
  byte_t      hw [6];
  byte_t      nw [6];
  logic [2:0] phase;
  len_t       position, length_held;
  byte_t      sender_held, command_held, received_sum, running_sum;

  logic       stream_active, pend;
  len_t       rd_idx, stream_len;
  byte_t      mem_q;

  logic       in_beat, out_beat, good_eot, wr_en, load, load_last;
  len_t       position_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !stream_active;
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= NODE_ADDR_RST;
      bcast_addr   <= BCAST_ADDR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_ADDR:  node_address <= cfg_data;
        REG_BCAST_ADDR: bcast_addr   <= cfg_data;
        default: ;
      endcase
    end
  end

  // window as it stands after shifting in this beat
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      nw[i] = hw[i+1];
    end
    nw[5] = rx_byte;
  end

  assign position_inc = position + 6'd1;
  assign good_eot = (rx_byte == CH_EOT) && (received_sum == running_sum) &&
                    (command_held == CMD_PACKET);
  assign wr_en = in_beat && (phase == PH_PAYLOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        hw[i] <= '0;
      end
      phase        <= PH_HUNT;
      position     <= '0;
      length_held  <= '0;
      sender_held  <= '0;
      command_held <= '0;
      received_sum <= '0;
      running_sum  <= '0;
    end else if (in_beat) begin
      case (phase)
        PH_HUNT: begin
          for (int i = 0; i < 6; i++) begin
            hw[i] <= nw[i];
          end
          if (nw[0] == CH_SOH && nw[5] == CH_STX && nw[1] != nw[2]) begin
            sender_held <= nw[2];
            if (nw[4] >= 8'(MAX_PAYLOAD) || nw[2] == node_address ||
                (nw[1] != node_address && nw[1] != bcast_addr)) begin
              // rejected header: frame stays reset
              phase        <= PH_HUNT;
              position     <= '0;
              length_held  <= '0;
              command_held <= '0;
              received_sum <= '0;
              running_sum  <= '0;
            end else begin
              command_held <= nw[3];
              running_sum  <= nw[1] + nw[2] + nw[3] + nw[4];
              position     <= '0;
              length_held  <= nw[4][5:0];
              phase        <= (nw[4][5:0] == '0) ? PH_ETX : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_sum <= running_sum + rx_byte;
          position    <= position_inc;
          if (position_inc == length_held) begin
            phase <= PH_ETX;
          end
        end
        PH_ETX: begin
          if (rx_byte == CH_ETX) begin
            phase <= PH_SUM;
          end else begin
            phase        <= PH_HUNT;
            position     <= '0;
            length_held  <= '0;
            command_held <= '0;
            received_sum <= '0;
            running_sum  <= '0;
          end
        end
        PH_SUM: begin
          received_sum <= rx_byte;
          phase        <= PH_EOT;
        end
        default: begin
          phase        <= PH_HUNT;
          position     <= '0;
          length_held  <= '0;
          command_held <= '0;
          received_sum <= '0;
          running_sum  <= '0;
        end
      endcase
    end
  end

  rfr_payload_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (position[AW-1:0]),
    .wr_data (rx_byte),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (mem_q)
  );

  // readout: issue read, then load the output register once it is free
  assign load      = stream_active && pend && (!out_valid || out_ready);
  assign load_last = (stream_len == '0) || (rd_idx + 6'd1 == stream_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_active <= 1'b0;
      pend          <= 1'b0;
      rd_idx        <= '0;
      stream_len    <= '0;
    end else if (in_beat && phase == PH_EOT && good_eot) begin
      stream_active <= 1'b1;
      pend          <= 1'b0;
      rd_idx        <= '0;
      stream_len    <= length_held;
    end else if (stream_active && !pend) begin
      pend <= 1'b1;
    end else if (load) begin
      pend   <= 1'b0;
      rd_idx <= rd_idx + 6'd1;
      if (load_last) begin
        stream_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sender       <= sender_held;
      frame_length <= stream_len;
      payload_byte <= (stream_len == '0) ? '0 : mem_q;
      byte_index   <= rd_idx;
      last         <= load_last;
    end
  end

  `RFR_ASSERT_NOW(a_pos_in_range, phase == PH_PAYLOAD, position < length_held, "payload position past length")
  `RFR_ASSERT_NOW(a_hunt_in_readout, stream_active, phase == PH_HUNT, "readout while a frame is open")
  `RFR_ASSERT_NOW(a_last_index, out_valid && last, (frame_length == '0 && byte_index == '0) || (byte_index + 6'd1 == frame_length), "last flag at wrong index")
  `RFR_ASSERT_NEXT(a_load_clears_pend, load, !pend, "read pending after output load")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the RS-485 frame receiver.
`timescale 1ns / 100ps

module tb;
  import rfr_pkg::*;

  localparam int DRAIN_CYCLES  = 16;
  localparam int SEGMENT_BYTES = 12;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic [2:0] {
    PH_HUNT, PH_PAYLOAD, PH_ETX, PH_CHECKSUM, PH_EOT
  } rx_phase_e;

  typedef enum int {
    FK_GOOD, FK_BAD_SUM, FK_BAD_ETX, FK_BAD_EOT, FK_BAD_CMD,
    FK_SELF_SRC, FK_FOREIGN_DST, FK_SAME_ADDR, FK_LONG_LEN, FK_NOISE
  } frame_kind_e;

  typedef struct packed {
    byte_t sender;
    len_t  frame_length;
    byte_t payload_byte;
    len_t  byte_index;
    logic  last;
  } rx_result_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_valid;
  logic  cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  byte_t cfg_data;
  logic  in_valid;
  logic  in_ready;
  byte_t rx_byte;
  logic  out_valid;
  logic  out_ready;
  byte_t sender;
  len_t  frame_length;
  byte_t payload_byte;
  len_t  byte_index;
  logic  last;

  rs485_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sender       (sender),
    .frame_length (frame_length),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

  always #2 clk = ~clk;

  // receiver-side copy of the parser state
  byte_t     node_addr_m;
  byte_t     bcast_addr_m;
  byte_t     hdr_win [6];
  rx_phase_e rx_phase;
  len_t      pos;
  len_t      len_held;
  byte_t     sender_held;
  byte_t     cmd_held;
  byte_t     rcv_sum;
  byte_t     run_sum;
  byte_t     pay_mem [64];

  rx_result_t payload_beats_due[$];
  byte_t      fixed_payload[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off;
  int sent_bytes;
  int rand_frames;
  int mismatches;

  function automatic void frame_clear();
    rx_phase = PH_HUNT;
    pos      = '0;
    len_held = '0;
    cmd_held = '0;
    rcv_sum  = '0;
    run_sum  = '0;
  endfunction

  function automatic void parser_init();
    node_addr_m  = NODE_ADDR_RST;
    bcast_addr_m = BCAST_ADDR_RST;
    sender_held  = '0;
    foreach (hdr_win[i]) hdr_win[i] = '0;
    foreach (pay_mem[i]) pay_mem[i] = '0;
    frame_clear();
  endfunction

  function automatic void parse_rx_byte(byte_t b);
    rx_result_t r;
    case (rx_phase)
      PH_HUNT: begin
        for (int i = 0; i < 5; i++) hdr_win[i] = hdr_win[i+1];
        hdr_win[5] = b;
        if (hdr_win[0] == CH_SOH && hdr_win[5] == CH_STX && hdr_win[1] != hdr_win[2]) begin
          sender_held = hdr_win[2];
          cmd_held    = hdr_win[3];
          run_sum     = hdr_win[1] + hdr_win[2] + hdr_win[3] + hdr_win[4];
          pos         = '0;
          rx_phase    = PH_PAYLOAD;
          if (hdr_win[4] >= MAX_PAYLOAD_DEF) begin
            frame_clear();
          end else begin
            len_held = hdr_win[4][5:0];
            if (hdr_win[2] == node_addr_m ||
                (hdr_win[1] != node_addr_m && hdr_win[1] != bcast_addr_m)) begin
              frame_clear();
            end else if (len_held == 0) begin
              rx_phase = PH_ETX;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        pay_mem[pos] = b;
        run_sum      = run_sum + b;
        pos          = pos + len_t'(1);
        if (pos == len_held) rx_phase = PH_ETX;
      end
      PH_ETX: begin
        if (b == CH_ETX) rx_phase = PH_CHECKSUM;
        else frame_clear();
      end
      PH_CHECKSUM: begin
        rcv_sum  = b;
        rx_phase = PH_EOT;
      end
      PH_EOT: begin
        if (b == CH_EOT && rcv_sum == run_sum && cmd_held == CMD_PACKET) begin
          if (len_held == 0) begin
            r = '{sender_held, len_t'(0), byte_t'(0), len_t'(0), 1'b1};
            payload_beats_due.push_back(r);
          end else begin
            for (int k = 0; k < len_held; k++) begin
              r = '{sender_held, len_held, pay_mem[k], len_t'(k), (k + 1 == len_held)};
              payload_beats_due.push_back(r);
            end
          end
        end
        frame_clear();
      end
      default: frame_clear();
    endcase
  endfunction

  // receiver ready; a hold-off count overrides the random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (payload_beats_due.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR unexpected beat: sender=%02h len=%0d data=%02h idx=%0d last=%0b",
                   sender, frame_length, payload_byte, byte_index, last);
        mismatches++;
      end else begin
        want = payload_beats_due.pop_front();
        if (sender !== want.sender || frame_length !== want.frame_length ||
            payload_byte !== want.payload_byte || byte_index !== want.byte_index ||
            last !== want.last) begin
          if (mismatches < 10)
            $display("ERROR beat: exp %02h/%0d/%02h/%0d/%0b got %02h/%0d/%02h/%0d/%0b",
                     want.sender, want.frame_length, want.payload_byte, want.byte_index,
                     want.last, sender, frame_length, payload_byte, byte_index, last);
          mismatches++;
        end
      end
    end
  end

  task automatic send_rx_byte(input byte_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b);
    sent_bytes++;
  endtask

  // stop offering, then wait for every pending beat plus the readout tail
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (payload_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input byte_t d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NODE_ADDR:  node_addr_m  = d;
      REG_BCAST_ADDR: bcast_addr_m = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_frame(input byte_t dst, input byte_t src, input byte_t cmd,
                            input byte_t len_field, input frame_kind_e kind);
    byte_t sum;
    byte_t b;
    sum = dst + src + cmd + len_field;
    send_rx_byte(CH_SOH);
    send_rx_byte(dst);
    send_rx_byte(src);
    send_rx_byte(cmd);
    send_rx_byte(len_field);
    send_rx_byte(CH_STX);
    if (len_field >= MAX_PAYLOAD_DEF) return;
    for (int i = 0; i < len_field; i++) begin
      b   = (fixed_payload.size() != 0) ? fixed_payload.pop_front() : byte_t'($urandom);
      sum = sum + b;
      send_rx_byte(b);
    end
    b = CH_ETX;
    if (kind == FK_BAD_ETX) do b = byte_t'($urandom); while (b == CH_ETX);
    send_rx_byte(b);
    if (kind == FK_BAD_SUM) sum = sum ^ byte_t'($urandom_range(1, 255));
    send_rx_byte(sum);
    b = CH_EOT;
    if (kind == FK_BAD_EOT) do b = byte_t'($urandom); while (b == CH_EOT);
    send_rx_byte(b);
  endtask

  function automatic byte_t pick_src(byte_t dst);
    byte_t s;
    do s = byte_t'($urandom); while (s == node_addr_m || s == dst);
    return s;
  endfunction

  task automatic send_random_frame();
    frame_kind_e kind;
    byte_t dst;
    byte_t src;
    byte_t cmd;
    byte_t len_field;
    // good frames alternate with a walk over every fault kind, then random kinds
    if (rand_frames[0] == 1'b0) kind = FK_GOOD;
    else if (rand_frames < 18) kind = frame_kind_e'(rand_frames / 2 + 1);
    else kind = frame_kind_e'($urandom_range(1, 9));
    rand_frames++;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 4)) send_rx_byte(byte_t'($urandom));
      return;
    end
    dst       = $urandom_range(1) ? node_addr_m : bcast_addr_m;
    src       = pick_src(dst);
    cmd       = CMD_PACKET;
    len_field = ($urandom_range(11) == 0) ? byte_t'($urandom_range(9, 63))
                                          : byte_t'($urandom_range(0, 8));
    case (kind)
      FK_BAD_CMD: do cmd = byte_t'($urandom); while (cmd == CMD_PACKET);
      FK_SELF_SRC: begin
        dst = bcast_addr_m;
        src = node_addr_m;
      end
      FK_FOREIGN_DST: begin
        do dst = byte_t'($urandom); while (dst == node_addr_m || dst == bcast_addr_m);
        src = pick_src(dst);
      end
      FK_SAME_ADDR: begin
        dst = node_addr_m;
        src = node_addr_m;
      end
      FK_LONG_LEN: len_field = byte_t'($urandom_range(MAX_PAYLOAD_DEF, 255));
      default: ;
    endcase
    send_frame(dst, src, cmd, len_field, kind);
  endtask

  task automatic test_zero_length_broadcast();
    send_idle_pct = 27;
    recv_idle_pct = 71;
    cfg_write(REG_NODE_ADDR, 8'h80);
    cfg_write(REG_BCAST_ADDR, 8'hFF);
    send_frame(8'hFF, 8'h00, CMD_PACKET, 8'd0, FK_GOOD);
  endtask

  task automatic test_length_limit();
    send_frame(8'h80, 8'h11, CMD_PACKET, byte_t'(MAX_PAYLOAD_DEF), FK_GOOD);
  endtask

  task automatic test_unicast_extremes();
    fixed_payload = '{8'h00, 8'hFF};
    send_frame(8'h80, 8'hFF, CMD_PACKET, 8'd2, FK_GOOD);
  endtask

  task automatic test_random_segment(input int s_idle, input int r_idle,
                                     input byte_t node, input byte_t bcast);
    int start;
    drain();
    cfg_write(REG_NODE_ADDR, node);
    cfg_write(REG_BCAST_ADDR, bcast);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start = sent_bytes;
    while (sent_bytes - start < SEGMENT_BYTES) send_random_frame();
    drain();
  endtask

  // long receiver stall during a readout; input must back up
  task automatic test_readout_backpressure();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = HOLD_CYCLES;
    send_frame(bcast_addr_m, pick_src(bcast_addr_m), CMD_PACKET, 8'd20, FK_GOOD);
    send_frame(node_addr_m, pick_src(node_addr_m), CMD_PACKET, 8'd0, FK_GOOD);
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = REG_NODE_ADDR;
    cfg_data      = '0;
    in_valid      = 1'b0;
    rx_byte       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = 0;
    sent_bytes    = 0;
    rand_frames   = 0;
    mismatches    = 0;
    parser_init();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_zero_length_broadcast();
    test_length_limit();
    test_unicast_extremes();
    test_random_segment(27, 71, 8'hFF, 8'h00);
    test_random_segment(71, 27, byte_t'($urandom), byte_t'($urandom));
    test_readout_backpressure();
    test_random_segment(0, 0, 8'h00, 8'hFF);
    begin : same_addr_cfg
      byte_t a;
      a = byte_t'($urandom);
      test_random_segment(0, 0, a, a);
    end

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
